// ===== hdl/ray_sphere_hit_sky_shade_defines.svh =====
// Assertion macros for the ray-sphere shading block.
`ifndef RAY_SPHERE_HIT_SKY_SHADE_DEFINES_SVH
`define RAY_SPHERE_HIT_SKY_SHADE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rss_pkg.sv =====
// Types and constants shared by the ray-sphere shading block.
package rss_pkg;
	localparam int COORD_W   = 16;
	localparam int RAD_W     = 15;
	localparam int OC_W      = 17;
	localparam int DD_W      = 31;
	localparam int OCD_W     = 33;
	localparam int OCOC_W    = 32;
	localparam int RR_W      = 30;
	localparam int A_W       = 32;
	localparam int H_W       = 35;
	localparam int C_W       = 35;
	localparam int RHS_W     = 55;
	localparam int P_W       = 60;
	localparam int Q_W       = 12;
	localparam int SQ_STEPS  = 12;
	localparam int N_STAGES  = 16;
	localparam int COLOR_W   = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic [COLOR_W-1:0] ONE_Q12  = 13'd4096;
	localparam logic [COLOR_W-1:0] HALF_Q12 = 13'd2048;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		coord_t             cx;
		coord_t             cy;
		coord_t             cz;
		logic [RAD_W-1:0]   r;
	} sphere_t;

	typedef logic [N_STAGES-1:0] stage_en_t;
endpackage

// ===== hdl/rss_ray_if.sv =====
// Ray channel: origin and direction with valid/ready.
interface rss_ray_if;
	import rss_pkg::*;
	logic   valid;
	logic   ready;
	coord_t origin_x;
	coord_t origin_y;
	coord_t origin_z;
	coord_t dir_x;
	coord_t dir_y;
	coord_t dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

// ===== hdl/rss_color_if.sv =====
// Colour channel: RGB result and hit flag with valid/ready.
interface rss_color_if;
	import rss_pkg::*;
	logic   valid;
	logic   ready;
	color_t red;
	color_t green;
	color_t blue;
	logic   hit;

	modport source (output valid, red, green, blue, hit, input ready);
	modport sink (input valid, red, green, blue, hit, output ready);
endinterface

// ===== hdl/ray_sphere_hit_sky_shade.sv =====
// Throughput: one ray per cycle while the colour output is not stalled.
// Each of the 16 pipeline stages holds while its successor is full and stalled,
// so a bubble anywhere lets a new ray in even while the output waits.
// The 12 sky stages resolve one bit of the gradient root each.
// Reset clears the stage valid bits and loads the sphere registers
// with centre (0, 0, -1.0) and radius 0.5.
`include "ray_sphere_hit_sky_shade_defines.svh"
module ray_sphere_hit_sky_shade (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rss_pkg::CFG_W-1:0]     cfg_data,
	rss_ray_if.sink                       ray,
	rss_color_if.source                   color
);
	import rss_pkg::*;

	sphere_t   sphere_q;
	logic      v_s [N_STAGES];
	stage_en_t en;

	logic [A_W-1:0]        a_s3;
	logic signed [H_W-1:0] h_s3;
	logic signed [C_W-1:0] c_s3;
	logic [RHS_W-1:0]      rhs_s3;
	logic                  azero_s3, dyneg_s3;
	logic                  hit_s15, azero_s15, dyneg_s15, hit_s16;
	logic [Q_W-1:0]        q_s15;
	color_t                red_s16, green_s16, blue_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_q.cx <= '0;
			sphere_q.cy <= '0;
			sphere_q.cz <= -16'sd4096;
			sphere_q.r  <= 15'd2048;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X: sphere_q.cx <= cfg_data;
				CFG_CENTER_Y: sphere_q.cy <= cfg_data;
				CFG_CENTER_Z: sphere_q.cz <= cfg_data;
				CFG_RADIUS:   sphere_q.r  <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		en[N_STAGES-1] = !v_s[N_STAGES-1] || color.ready;
		for (int i = N_STAGES - 2; i >= 0; i--)
			en[i] = !v_s[i] || en[i+1];
	end

	for (genvar g = 0; g < N_STAGES; g++) begin : g_valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g] <= 1'b0;
			else if (en[g])
				v_s[g] <= (g == 0) ? ray.valid : v_s[(g == 0) ? 0 : g-1];
		end
	end

	assign ray.ready = en[0];

	rss_geom u_geom (
		.clk(clk), .en(en), .sphere(sphere_q),
		.origin_x(ray.origin_x), .origin_y(ray.origin_y), .origin_z(ray.origin_z),
		.dir_x(ray.dir_x), .dir_y(ray.dir_y), .dir_z(ray.dir_z),
		.a_s3(a_s3), .h_s3(h_s3), .c_s3(c_s3), .rhs_s3(rhs_s3),
		.azero_s3(azero_s3), .dyneg_s3(dyneg_s3)
	);

	rss_disc u_disc (
		.clk(clk), .en(en), .a_s3(a_s3), .h_s3(h_s3), .c_s3(c_s3), .hit_s15(hit_s15)
	);

	rss_sky u_sky (
		.clk(clk), .en(en), .a_s3(a_s3), .rhs_s3(rhs_s3),
		.azero_s3(azero_s3), .dyneg_s3(dyneg_s3),
		.q_s15(q_s15), .azero_s15(azero_s15), .dyneg_s15(dyneg_s15)
	);

	rss_shade u_shade (
		.clk(clk), .en(en), .hit_s15(hit_s15), .q_s15(q_s15),
		.azero_s15(azero_s15), .dyneg_s15(dyneg_s15),
		.red_s16(red_s16), .green_s16(green_s16), .blue_s16(blue_s16),
		.hit_s16(hit_s16)
	);

	assign color.valid = v_s[N_STAGES-1];
	assign color.red   = red_s16;
	assign color.green = green_s16;
	assign color.blue  = blue_s16;
	assign color.hit   = hit_s16;

	`RSS_ASSERT_NOW(a_hit_red, color.valid && color.hit,
		color.red == ONE_Q12 && color.green == '0 && color.blue == '0, "hit colour not red")
	`RSS_ASSERT_NOW(a_sky_range, color.valid && !color.hit,
		color.blue == ONE_Q12 && color.red >= HALF_Q12 && color.red <= ONE_Q12,
		"sky colour out of range")
	`RSS_ASSERT_NOW(a_full_stall, !ray.ready,
		v_s[0] && v_s[N_STAGES-1] && !color.ready, "input held with a bubble free")
	`RSS_ASSERT_NEXT(a_enter, ray.valid && ray.ready, v_s[0], "transfer not captured")
endmodule

// ===== hdl/rss_geom.sv =====
// Stages 1 to 3: offsets, products and the dot-product sums a, h and c.
module rss_geom (
	input  logic                       clk,
	input  rss_pkg::stage_en_t         en,
	input  rss_pkg::sphere_t           sphere,
	input  rss_pkg::coord_t            origin_x,
	input  rss_pkg::coord_t            origin_y,
	input  rss_pkg::coord_t            origin_z,
	input  rss_pkg::coord_t            dir_x,
	input  rss_pkg::coord_t            dir_y,
	input  rss_pkg::coord_t            dir_z,
	output logic [rss_pkg::A_W-1:0]    a_s3,
	output logic signed [rss_pkg::H_W-1:0] h_s3,
	output logic signed [rss_pkg::C_W-1:0] c_s3,
	output logic [rss_pkg::RHS_W-1:0]  rhs_s3,
	output logic                       azero_s3,
	output logic                       dyneg_s3
);
	import rss_pkg::*;

	logic signed [OC_W-1:0]  ocx_s1, ocy_s1, ocz_s1;
	coord_t                  dx_s1, dy_s1, dz_s1;

	logic signed [2*COORD_W-1:0] ddx, ddy, ddz;
	logic signed [OCD_W-1:0]     ocdx, ocdy, ocdz;
	logic signed [2*OC_W-1:0]    ococx, ococy, ococz;
	logic [RR_W-1:0]             rr;

	logic [DD_W-1:0]   ddx_s2, ddy_s2, ddz_s2;
	logic signed [OCD_W-1:0] ocdx_s2, ocdy_s2, ocdz_s2;
	logic [OCOC_W-1:0] ococx_s2, ococy_s2, ococz_s2;
	logic [RR_W-1:0]   rr_s2;
	logic              dyneg_s2;

	logic [A_W-1:0]        a_sum;
	logic signed [H_W-1:0] h_sum;
	logic signed [C_W-1:0] c_sum;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ocx_s1 <= OC_W'(origin_x) - OC_W'(sphere.cx);
			ocy_s1 <= OC_W'(origin_y) - OC_W'(sphere.cy);
			ocz_s1 <= OC_W'(origin_z) - OC_W'(sphere.cz);
			dx_s1  <= dir_x;
			dy_s1  <= dir_y;
			dz_s1  <= dir_z;
		end
	end

	assign ddx   = dx_s1 * dx_s1;
	assign ddy   = dy_s1 * dy_s1;
	assign ddz   = dz_s1 * dz_s1;
	assign ocdx  = ocx_s1 * dx_s1;
	assign ocdy  = ocy_s1 * dy_s1;
	assign ocdz  = ocz_s1 * dz_s1;
	assign ococx = ocx_s1 * ocx_s1;
	assign ococy = ocy_s1 * ocy_s1;
	assign ococz = ocz_s1 * ocz_s1;
	assign rr    = RR_W'(sphere.r) * RR_W'(sphere.r);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ddx_s2   <= ddx[DD_W-1:0];
			ddy_s2   <= ddy[DD_W-1:0];
			ddz_s2   <= ddz[DD_W-1:0];
			ocdx_s2  <= ocdx;
			ocdy_s2  <= ocdy;
			ocdz_s2  <= ocdz;
			ococx_s2 <= ococx[OCOC_W-1:0];
			ococy_s2 <= ococy[OCOC_W-1:0];
			ococz_s2 <= ococz[OCOC_W-1:0];
			rr_s2    <= rr;
			dyneg_s2 <= dy_s1[COORD_W-1];
		end
	end

	assign a_sum = A_W'(ddx_s2) + A_W'(ddy_s2) + A_W'(ddz_s2);
	assign h_sum = H_W'(ocdx_s2) + H_W'(ocdy_s2) + H_W'(ocdz_s2);
	assign c_sum = $signed({3'b0, ococx_s2}) + $signed({3'b0, ococy_s2})
		+ $signed({3'b0, ococz_s2}) - $signed({5'b0, rr_s2});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			a_s3     <= a_sum;
			h_s3     <= h_sum;
			c_s3     <= c_sum;
			rhs_s3   <= {ddy_s2, 24'b0};
			azero_s3 <= (a_sum == '0);
			dyneg_s3 <= dyneg_s2;
		end
	end
endmodule

// ===== hdl/rss_disc.sv =====
// Stages 4 to 15: discriminant h*h - a*c by partial products, then hit delay.
module rss_disc (
	input  logic                           clk,
	input  rss_pkg::stage_en_t             en,
	input  logic [rss_pkg::A_W-1:0]        a_s3,
	input  logic signed [rss_pkg::H_W-1:0] h_s3,
	input  logic signed [rss_pkg::C_W-1:0] c_s3,
	output logic                           hit_s15
);
	import rss_pkg::*;

	localparam int DLY = 10;

	logic [H_W-1:0]         hneg;
	logic [32:0]            habs;
	logic [33:0]            ll;
	logic [32:0]            lh;
	logic [31:0]            hhp;
	logic [49:0]            aclo;
	logic signed [49:0]     achi;

	logic [33:0]        ll_s4;
	logic [32:0]        lh_s4;
	logic [31:0]        hh_s4;
	logic [49:0]        aclo_s4;
	logic signed [49:0] achi_s4;

	logic [65:0]        hsq;
	logic signed [67:0] ac;
	logic signed [69:0] disc;

	logic hit_s5;
	logic hit_dly_s [DLY];

	assign hneg = h_s3[H_W-1] ? H_W'(-h_s3) : H_W'(h_s3);
	assign habs = hneg[32:0];
	assign ll   = 34'(habs[16:0]) * 34'(habs[16:0]);
	assign lh   = 33'(habs[16:0]) * 33'(habs[32:17]);
	assign hhp  = 32'(habs[32:17]) * 32'(habs[32:17]);
	assign aclo = 50'(a_s3) * 50'(c_s3[17:0]);
	assign achi = $signed({1'b0, a_s3}) * $signed(c_s3[C_W-1:18]);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ll_s4   <= ll;
			lh_s4   <= lh;
			hh_s4   <= hhp;
			aclo_s4 <= aclo;
			achi_s4 <= achi;
		end
	end

	assign hsq  = 66'(ll_s4) + (66'(lh_s4) << 18) + (66'(hh_s4) << 34);
	assign ac   = $signed({18'b0, aclo_s4}) + (68'(achi_s4) <<< 18);
	assign disc = $signed({4'b0, hsq}) - 70'(ac);

	always_ff @(posedge clk) begin
		if (en[4])
			hit_s5 <= !disc[69] && (disc != '0);
	end

	for (genvar g = 0; g < DLY; g++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[5+g]) begin
				if (g == 0)
					hit_dly_s[g] <= hit_s5;
				else
					hit_dly_s[g] <= hit_dly_s[(g == 0) ? 0 : g-1];
			end
		end
	end

	assign hit_s15 = hit_dly_s[DLY-1];
endmodule

// ===== hdl/rss_sky.sv =====
// Stages 4 to 15: one bit of q per stage, incremental square test on (2q-1)^2*a.
module rss_sky (
	input  logic                          clk,
	input  rss_pkg::stage_en_t            en,
	input  logic [rss_pkg::A_W-1:0]       a_s3,
	input  logic [rss_pkg::RHS_W-1:0]     rhs_s3,
	input  logic                          azero_s3,
	input  logic                          dyneg_s3,
	output logic [rss_pkg::Q_W-1:0]       q_s15,
	output logic                          azero_s15,
	output logic                          dyneg_s15
);
	import rss_pkg::*;

	logic signed [P_W-1:0] sq_p_s [SQ_STEPS];
	logic signed [P_W-1:0] sq_qa_s [SQ_STEPS];
	logic [Q_W-1:0]        sq_q_s [SQ_STEPS];
	logic [A_W-1:0]        sq_a_s [SQ_STEPS];
	logic [RHS_W-1:0]      sq_rhs_s [SQ_STEPS];
	logic                  sq_az_s [SQ_STEPS];
	logic                  sq_neg_s [SQ_STEPS];

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		localparam int B = SQ_STEPS - 1 - g;
		logic signed [P_W-1:0] p_in, qa_in, a_ext, rhs_ext, cand;
		logic [Q_W-1:0]        q_in;
		logic [A_W-1:0]        a_in;
		logic [RHS_W-1:0]      rhs_in;
		logic                  az_in, neg_in, take;

		always_comb begin
			if (g == 0) begin
				a_in   = a_s3;
				rhs_in = rhs_s3;
				az_in  = azero_s3;
				neg_in = dyneg_s3;
				q_in   = '0;
			end else begin
				a_in   = sq_a_s[(g == 0) ? 0 : g-1];
				rhs_in = sq_rhs_s[(g == 0) ? 0 : g-1];
				az_in  = sq_az_s[(g == 0) ? 0 : g-1];
				neg_in = sq_neg_s[(g == 0) ? 0 : g-1];
				q_in   = sq_q_s[(g == 0) ? 0 : g-1];
			end
			a_ext   = $signed({{(P_W-A_W){1'b0}}, a_in});
			rhs_ext = $signed({{(P_W-RHS_W){1'b0}}, rhs_in});
			if (g == 0) begin
				p_in  = a_ext;
				qa_in = -a_ext;
			end else begin
				p_in  = sq_p_s[(g == 0) ? 0 : g-1];
				qa_in = sq_qa_s[(g == 0) ? 0 : g-1];
			end
			cand = p_in + (qa_in <<< (B + 2)) + (a_ext <<< (2*B + 2));
			take = (cand <= rhs_ext);
		end

		always_ff @(posedge clk) begin
			if (en[3+g]) begin
				sq_p_s[g]   <= take ? cand : p_in;
				sq_qa_s[g]  <= take ? qa_in + (a_ext <<< (B + 1)) : qa_in;
				sq_q_s[g]   <= take ? (q_in | (Q_W'(1) << B)) : q_in;
				sq_a_s[g]   <= a_in;
				sq_rhs_s[g] <= rhs_in;
				sq_az_s[g]  <= az_in;
				sq_neg_s[g] <= neg_in;
			end
		end
	end

	assign q_s15     = sq_q_s[SQ_STEPS-1];
	assign azero_s15 = sq_az_s[SQ_STEPS-1];
	assign dyneg_s15 = sq_neg_s[SQ_STEPS-1];
endmodule

// ===== hdl/rss_shade.sv =====
// Stage 16: sky gradient from q, or pure red on a hit.
module rss_shade (
	input  logic                    clk,
	input  rss_pkg::stage_en_t      en,
	input  logic                    hit_s15,
	input  logic [rss_pkg::Q_W-1:0] q_s15,
	input  logic                    azero_s15,
	input  logic                    dyneg_s15,
	output rss_pkg::color_t         red_s16,
	output rss_pkg::color_t         green_s16,
	output rss_pkg::color_t         blue_s16,
	output logic                    hit_s16
);
	import rss_pkg::*;

	color_t      t;
	logic [13:0] t1;
	logic [14:0] x;
	logic [30:0] m;
	color_t      sky_r, sky_g;

	always_comb begin
		if (azero_s15)
			t = HALF_Q12;
		else if (dyneg_s15)
			t = HALF_Q12 - COLOR_W'(q_s15);
		else
			t = HALF_Q12 + COLOR_W'(q_s15);
		t1    = 14'(t) + 14'd1;
		x     = 15'(t) * 15'd3 + 15'd5;
		// floor(x / 10) by reciprocal, exact for every value of the 15-bit x
		m     = 31'(x) * 31'd52429;
		sky_r = ONE_Q12 - COLOR_W'(t1 >> 1);
		sky_g = ONE_Q12 - COLOR_W'(m[30:19]);
	end

	always_ff @(posedge clk) begin
		if (en[15]) begin
			red_s16   <= hit_s15 ? ONE_Q12 : sky_r;
			green_s16 <= hit_s15 ? '0 : sky_g;
			blue_s16  <= hit_s15 ? '0 : ONE_Q12;
			hit_s16   <= hit_s15;
		end
	end
endmodule
